// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the gradient block. They expect clk and rst_n
// in the scope where they are used.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define SVG_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// The condition must never be true at a clock edge outside reset.
`define SVG_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ===== hdl/svg_pkg.sv =====
// ----------------------------------------------------------------------------
// svg_pkg
// Types and constants shared by the vertical Sobel gradient modules.
// ----------------------------------------------------------------------------
package svg_pkg;

    localparam int MAX_WIDTH_DEF = 4096;

    localparam int PIX_W  = 8;
    localparam int CNT_W  = 12;
    localparam int DIM_W  = 13;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 13;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'd1;

    localparam logic [DIM_W-1:0] IMAGE_WIDTH_RST  = 13'd640;
    localparam logic [DIM_W-1:0] IMAGE_HEIGHT_RST = 13'd480;
    localparam logic [DIM_W-1:0] DIM_MIN          = 13'd3;
    localparam logic [DIM_W-1:0] HEIGHT_MAX       = 13'd4096;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = 2;
    localparam int LVL_W  = 3;

    typedef struct packed {
        logic [2:0][PIX_W-1:0] top_row;
        logic [2:0][PIX_W-1:0] bot_row;
        logic [CNT_W-1:0]      row;
        logic [CNT_W-1:0]      col;
        logic                  last;
    } job_t;

endpackage

// ===== hdl/svg_ram.sv =====
// ----------------------------------------------------------------------------
// svg_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module svg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/svg_front.sv =====
// ----------------------------------------------------------------------------
// svg_front
// Accepts pixels, keeps the raster counters and configuration, reads and
// updates the two line stores, shifts the window and queues interior jobs.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module svg_front #(
    parameter int MAX_WIDTH = svg_pkg::MAX_WIDTH_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [svg_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [svg_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                             pix_valid,
    output logic                             pix_ready,
    input  logic [svg_pkg::PIX_W-1:0]        pix_data,
    input  logic [svg_pkg::LVL_W-1:0]        level,
    output logic                             push_valid,
    output svg_pkg::job_t                    push_job
);

    localparam int ADDR_W  = $clog2(MAX_WIDTH);
    localparam int IDX_MAX = MAX_WIDTH - 1;
    localparam int WMAX    = (MAX_WIDTH < 4096) ? MAX_WIDTH : 4096;
    localparam logic [svg_pkg::DIM_W-1:0] WIDTH_MAX = svg_pkg::DIM_W'(WMAX);

    logic [svg_pkg::DIM_W-1:0] width_cfg_reg;
    logic [svg_pkg::DIM_W-1:0] height_cfg_reg;
    logic [svg_pkg::DIM_W-1:0] w_eff;
    logic [svg_pkg::DIM_W-1:0] h_eff;

    logic [svg_pkg::CNT_W-1:0] col_reg;
    logic [svg_pkg::CNT_W-1:0] col_next;
    logic [svg_pkg::CNT_W-1:0] row_reg;
    logic [svg_pkg::CNT_W-1:0] row_next;
    logic [svg_pkg::DIM_W-1:0] c13;
    logic [svg_pkg::DIM_W-1:0] r13;
    logic [ADDR_W-1:0]         idx;
    logic                      accept;
    logic                      emit;
    logic                      last;

    logic                      s1_valid_reg;
    logic [svg_pkg::PIX_W-1:0] s1_pix_reg;
    logic [ADDR_W-1:0]         s1_idx_reg;
    logic                      s1_emit_reg;
    logic                      s1_last_reg;
    logic [svg_pkg::CNT_W-1:0] s1_row_reg;
    logic [svg_pkg::CNT_W-1:0] s1_col_reg;

    logic [svg_pkg::PIX_W-1:0] upper_rd;
    logic [svg_pkg::PIX_W-1:0] middle_rd;
    logic [1:0][svg_pkg::PIX_W-1:0] top_reg;
    logic [1:0][svg_pkg::PIX_W-1:0] bot_reg;

    always_comb
    begin
        if (width_cfg_reg < svg_pkg::DIM_MIN)
        begin
            w_eff = svg_pkg::DIM_MIN;
        end
        else if (width_cfg_reg > WIDTH_MAX)
        begin
            w_eff = WIDTH_MAX;
        end
        else
        begin
            w_eff = width_cfg_reg;
        end
        if (height_cfg_reg < svg_pkg::DIM_MIN)
        begin
            h_eff = svg_pkg::DIM_MIN;
        end
        else if (height_cfg_reg > svg_pkg::HEIGHT_MAX)
        begin
            h_eff = svg_pkg::HEIGHT_MAX;
        end
        else
        begin
            h_eff = height_cfg_reg;
        end
    end

    assign pix_ready = ({{(svg_pkg::LVL_W-1){1'b0}}, s1_valid_reg} + level)
                       < svg_pkg::LVL_W'(svg_pkg::QDEPTH);
    assign accept = pix_valid && pix_ready;

    assign c13 = {1'b0, col_reg};
    assign r13 = {1'b0, row_reg};

    always_comb
    begin
        if (32'(col_reg) > 32'(IDX_MAX))
        begin
            idx = ADDR_W'(IDX_MAX);
        end
        else
        begin
            idx = ADDR_W'(col_reg);
        end
        emit = (c13 >= 13'd2) && (c13 < w_eff) && (r13 >= 13'd2) && (r13 < h_eff);
        last = (c13 == w_eff - 13'd1) && (r13 == h_eff - 13'd1);
        col_next = col_reg;
        row_next = row_reg;
        if (c13 + 13'd1 >= w_eff)
        begin
            col_next = '0;
            if (r13 + 13'd1 >= h_eff)
            begin
                row_next = '0;
            end
            else
            begin
                row_next = row_reg + 12'd1;
            end
        end
        else
        begin
            col_next = col_reg + 12'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_cfg_reg  <= svg_pkg::IMAGE_WIDTH_RST;
            height_cfg_reg <= svg_pkg::IMAGE_HEIGHT_RST;
            col_reg        <= '0;
            row_reg        <= '0;
            s1_valid_reg   <= 1'b0;
            top_reg        <= '0;
            bot_reg        <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    svg_pkg::REG_IMAGE_WIDTH:  width_cfg_reg  <= cfg_data;
                    svg_pkg::REG_IMAGE_HEIGHT: height_cfg_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (accept)
            begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
            s1_valid_reg <= accept;
            if (s1_valid_reg)
            begin
                top_reg <= {upper_rd, top_reg[1]};
                bot_reg <= {s1_pix_reg, bot_reg[1]};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_pix_reg  <= pix_data;
            s1_idx_reg  <= idx;
            s1_emit_reg <= emit;
            s1_last_reg <= last;
            s1_row_reg  <= row_reg - 12'd1;
            s1_col_reg  <= col_reg - 12'd1;
        end
    end

    svg_ram #(
        .WIDTH (svg_pkg::PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_upper (
        .clk   (clk),
        .we    (s1_valid_reg),
        .waddr (s1_idx_reg),
        .wdata (middle_rd),
        .re    (accept),
        .raddr (idx),
        .rdata (upper_rd)
    );

    svg_ram #(
        .WIDTH (svg_pkg::PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_middle (
        .clk   (clk),
        .we    (s1_valid_reg),
        .waddr (s1_idx_reg),
        .wdata (s1_pix_reg),
        .re    (accept),
        .raddr (idx),
        .rdata (middle_rd)
    );

    assign push_valid       = s1_valid_reg && s1_emit_reg;
    assign push_job.top_row = {upper_rd, top_reg[1], top_reg[0]};
    assign push_job.bot_row = {s1_pix_reg, bot_reg[1], bot_reg[0]};
    assign push_job.row     = s1_row_reg;
    assign push_job.col     = s1_col_reg;
    assign push_job.last    = s1_last_reg;

    `SVG_ASSERT(a_accept_reaches_s1, accept |=> s1_valid_reg, "accepted pixel lost before window")
    `SVG_NEVER(a_no_border_job, push_valid && (s1_row_reg == '0 || s1_col_reg == '0), "border job")

endmodule

// ===== hdl/svg_back.sv =====
// ----------------------------------------------------------------------------
// svg_back
// Holds the job queue, computes the clamped vertical gradient of the head
// job and presents it in the output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module svg_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push_valid,
    input  svg_pkg::job_t               push_job,
    output logic [svg_pkg::LVL_W-1:0]   level,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [svg_pkg::CNT_W-1:0]   out_row,
    output logic [svg_pkg::CNT_W-1:0]   out_col,
    output logic [svg_pkg::PIX_W-1:0]   out_grey,
    output logic                        out_last
);

    svg_pkg::job_t                q_reg [svg_pkg::QDEPTH];
    logic [svg_pkg::QPTR_W-1:0]   wr_ptr_reg;
    logic [svg_pkg::QPTR_W-1:0]   rd_ptr_reg;
    logic [svg_pkg::LVL_W-1:0]    level_reg;
    logic [svg_pkg::LVL_W-1:0]    level_next;
    logic                         pop;
    svg_pkg::job_t                head;

    logic [9:0]                   sum_top;
    logic [9:0]                   sum_bot;
    logic signed [10:0]           diff;
    logic [svg_pkg::PIX_W-1:0]    grey;

    logic                         out_valid_reg;
    logic [svg_pkg::CNT_W-1:0]    out_row_reg;
    logic [svg_pkg::CNT_W-1:0]    out_col_reg;
    logic [svg_pkg::PIX_W-1:0]    out_grey_reg;
    logic                         out_last_reg;

    assign head = q_reg[rd_ptr_reg];
    assign pop  = (level_reg != '0) && (!out_valid_reg || out_ready);

    always_comb
    begin
        sum_top = {2'b00, head.top_row[0]} + {1'b0, head.top_row[1], 1'b0}
                + {2'b00, head.top_row[2]};
        sum_bot = {2'b00, head.bot_row[0]} + {1'b0, head.bot_row[1], 1'b0}
                + {2'b00, head.bot_row[2]};
        diff = $signed({1'b0, sum_top}) - $signed({1'b0, sum_bot});
        if (diff < 11'sd0)
        begin
            grey = '0;
        end
        else if (diff > 11'sd255)
        begin
            grey = 8'd255;
        end
        else
        begin
            grey = diff[7:0];
        end
        level_next = level_reg + {{(svg_pkg::LVL_W-1){1'b0}}, push_valid}
                   - {{(svg_pkg::LVL_W-1){1'b0}}, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg    <= '0;
            rd_ptr_reg    <= '0;
            level_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (push_valid)
            begin
                wr_ptr_reg <= wr_ptr_reg + svg_pkg::QPTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + svg_pkg::QPTR_W'(1);
            end
            level_reg <= level_next;
            if (pop)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_valid)
        begin
            q_reg[wr_ptr_reg] <= push_job;
        end
        if (pop)
        begin
            out_row_reg  <= head.row;
            out_col_reg  <= head.col;
            out_grey_reg <= grey;
            out_last_reg <= head.last;
        end
    end

    assign level     = level_reg;
    assign out_valid = out_valid_reg;
    assign out_row   = out_row_reg;
    assign out_col   = out_col_reg;
    assign out_grey  = out_grey_reg;
    assign out_last  = out_last_reg;

    `SVG_NEVER(a_q_overflow, push_valid && !pop && 32'(level_reg) == svg_pkg::QDEPTH, "queue overflow")
    `SVG_NEVER(a_q_level_range, 32'(level_reg) > svg_pkg::QDEPTH, "queue level out of range")
    `SVG_ASSERT(a_pop_loads_out, pop |=> out_valid_reg, "popped job not presented")

endmodule

// ===== hdl/sobel_vertical_gradient_clamp.sv =====
// ----------------------------------------------------------------------------
// sobel_vertical_gradient_clamp
// Streaming 3x3 vertical Sobel gradient, clamped to 0..255.
// ----------------------------------------------------------------------------
// Pixels enter on the s_axis channel in raster order, one blue component per
// transfer. For every interior pixel of the frame one result leaves on the
// m_axis channel carrying its row, column and clamped gradient; tlast marks
// the final interior pixel of the frame. Border pixels produce no result.
// Image width and height are set through the cfg port; the user must write
// them only while the block is idle; the block itself does not enforce it.
// Out-of-range values are saturated to 3..4096 (width also to the line
// store depth). Throughput is one pixel per clock while s_axis_tready is
// high. The result of the pixel that completes a window passes through the
// line store read stage and the job queue before the output register loads.
// Reset clears the raster counters, the window and the queue and restores
// the default 640x480 size; line store contents are not cleared.
// When m_axis stalls, results collect in a four-entry queue and s_axis
// tready drops once the queue and the line store read stage could fill it.
// ----------------------------------------------------------------------------
module sobel_vertical_gradient_clamp #(
    parameter int MAX_WIDTH = svg_pkg::MAX_WIDTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [svg_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [svg_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [7:0]                     s_axis_tdata,  // pixel_blue
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [31:0]                    m_axis_tdata,  // out_row, out_col, grey_level
    output logic                           m_axis_tlast   // last_pixel
);

    logic                            push_valid;
    svg_pkg::job_t                   push_job;
    logic [svg_pkg::LVL_W-1:0]       level;
    logic [svg_pkg::CNT_W-1:0]       out_row;
    logic [svg_pkg::CNT_W-1:0]       out_col;
    logic [svg_pkg::PIX_W-1:0]       out_grey;

    svg_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .pix_valid  (s_axis_tvalid),
        .pix_ready  (s_axis_tready),
        .pix_data   (s_axis_tdata),
        .level      (level),
        .push_valid (push_valid),
        .push_job   (push_job)
    );

    svg_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_job   (push_job),
        .level      (level),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_row    (out_row),
        .out_col    (out_col),
        .out_grey   (out_grey),
        .out_last   (m_axis_tlast)
    );

    assign m_axis_tdata = {out_grey, out_col, out_row};

endmodule

// ===== sim/tb_sobel_vertical_gradient_clamp.sv =====
// ----------------------------------------------------------------------------
// tb_sobel_vertical_gradient_clamp
// Self-checking testbench for the streaming vertical Sobel gradient block.
// ----------------------------------------------------------------------------
// Pixels are streamed into the block in raster order while a scoreboard
// keeps its own copy of the line stores, the 3x3 window and the raster
// counters. Every accepted pixel updates that copy, and every interior pixel
// queues the expected row, column, clamped gradient and end-of-frame flag.
// Each result transfer is compared with the oldest queued entry. The run
// starts with a short hand-built frame, continues with random frames of
// varying size under three patterns of source and sink stalls, and ends with
// a first row that runs far past the reset width, a frame whose height
// register lies above the limit, and the smallest frame. Size changes are
// made only while the block is quiet, some of them in the middle of a frame.
// ----------------------------------------------------------------------------
module tb_sobel_vertical_gradient_clamp;

    localparam int LINE_DEPTH    = svg_pkg::MAX_WIDTH_DEF;
    localparam int WIDTH_CAP     = (svg_pkg::MAX_WIDTH_DEF < 4096) ? svg_pkg::MAX_WIDTH_DEF : 4096;
    localparam int SETTLE_CYCLES = 8;
    localparam int CYCLE_LIMIT   = 600000;
    localparam int RANDOM_ITEMS  = 360;
    localparam int WIDE_PIXELS   = 680;
    localparam int TALL_ROWS     = 6;

    typedef struct {
        logic [svg_pkg::CNT_W-1:0] row;
        logic [svg_pkg::CNT_W-1:0] col;
        logic [svg_pkg::PIX_W-1:0] grey;
        logic                      last;
    } grad_result_t;

    class sobel_grad_scoreboard;
        bit [svg_pkg::DIM_W-1:0] width_reg;
        bit [svg_pkg::DIM_W-1:0] height_reg;
        bit [svg_pkg::PIX_W-1:0] line_upper [LINE_DEPTH];
        bit [svg_pkg::PIX_W-1:0] line_middle [LINE_DEPTH];
        bit [svg_pkg::PIX_W-1:0] window [9];
        bit [svg_pkg::CNT_W-1:0] col_cnt;
        bit [svg_pkg::CNT_W-1:0] row_cnt;
        grad_result_t            expected_grads [$];
        int                      errors;
        int                      pixels_seen;
        int                      grads_checked;
        int                      clamped_high;
        int                      clamped_low;
        int                      frames_done;

        function new();
            width_reg  = svg_pkg::IMAGE_WIDTH_RST;
            height_reg = svg_pkg::IMAGE_HEIGHT_RST;
            foreach (window[k])
                window[k] = '0;
            col_cnt = '0;
            row_cnt = '0;
        endfunction

        function int clip_dim(bit [svg_pkg::DIM_W-1:0] v, int hi);
            if (int'(v) < 3)
                return 3;
            if (int'(v) > hi)
                return hi;
            return int'(v);
        endfunction

        function int eff_width();
            return clip_dim(width_reg, WIDTH_CAP);
        endfunction

        function void write_reg(logic [svg_pkg::CFG_IDX_W-1:0] idx,
                                bit [svg_pkg::DIM_W-1:0] val);
            if (idx == svg_pkg::REG_IMAGE_WIDTH)
                width_reg = val;
            else if (idx == svg_pkg::REG_IMAGE_HEIGHT)
                height_reg = val;
        endfunction

        function void note_pixel(bit [svg_pkg::PIX_W-1:0] pix);
            int                      w;
            int                      h;
            int                      c;
            int                      r;
            int                      idx;
            int                      g;
            bit [svg_pkg::PIX_W-1:0] top;
            bit [svg_pkg::PIX_W-1:0] mid;
            grad_result_t            e;
            w   = eff_width();
            h   = clip_dim(height_reg, 4096);
            c   = int'(col_cnt);
            r   = int'(row_cnt);
            idx = (c < LINE_DEPTH) ? c : LINE_DEPTH - 1;
            top = line_upper[idx];
            mid = line_middle[idx];
            line_upper[idx]  = mid;
            line_middle[idx] = pix;
            for (int k = 0; k < 3; k++)
            begin
                window[k*3]   = window[k*3+1];
                window[k*3+1] = window[k*3+2];
            end
            window[2] = top;
            window[5] = mid;
            window[8] = pix;
            pixels_seen++;
            if (c >= 2 && c < w && r >= 2 && r < h)
            begin
                g = int'(window[0]) + 2 * int'(window[1]) + int'(window[2])
                  - int'(window[6]) - 2 * int'(window[7]) - int'(window[8]);
                if (g > 255)
                begin
                    g = 255;
                    clamped_high++;
                end
                if (g < 0)
                begin
                    g = 0;
                    clamped_low++;
                end
                e.row  = svg_pkg::CNT_W'(r - 1);
                e.col  = svg_pkg::CNT_W'(c - 1);
                e.grey = svg_pkg::PIX_W'(g);
                e.last = (c == w - 1 && r == h - 1);
                expected_grads.push_back(e);
            end
            if (c + 1 >= w)
            begin
                col_cnt = '0;
                if (r + 1 >= h)
                begin
                    row_cnt = '0;
                    frames_done++;
                end
                else
                    row_cnt = svg_pkg::CNT_W'(r + 1);
            end
            else
                col_cnt = svg_pkg::CNT_W'(c + 1);
        endfunction

        function void check_result(bit [31:0] data, bit last_bit);
            grad_result_t e;
            grad_result_t got;
            got.row  = data[11:0];
            got.col  = data[23:12];
            got.grey = data[31:24];
            got.last = last_bit;
            if (expected_grads.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("Unexpected result: row %0d col %0d grey %0d last %0b",
                             got.row, got.col, got.grey, got.last);
                return;
            end
            e = expected_grads.pop_front();
            grads_checked++;
            if (got.row !== e.row || got.col !== e.col || got.grey !== e.grey
                || got.last !== e.last)
            begin
                errors++;
                if (errors <= 10)
                    $display("Mismatch: expected row %0d col %0d grey %0d last %0b, got row %0d col %0d grey %0d last %0b",
                             e.row, e.col, e.grey, e.last,
                             got.row, got.col, got.grey, got.last);
            end
        endfunction
    endclass

    logic                           clk;
    logic                           rst_n;
    logic                           cfg_we;
    logic [svg_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [svg_pkg::CFG_DATA_W-1:0] cfg_data;
    logic                           s_axis_tvalid;
    logic                           s_axis_tready;
    logic [7:0]                     s_axis_tdata;
    logic                           m_axis_tvalid;
    logic                           m_axis_tready;
    logic [31:0]                    m_axis_tdata;
    logic                           m_axis_tlast;

    sobel_grad_scoreboard grads;
    int                   src_idle_pct;
    int                   dst_idle_pct;
    bit                   quiet;
    int                   cycle_count;
    int                   reg_writes;

    sobel_vertical_gradient_clamp dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("FAILED: results differ");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
                grads.check_result(m_axis_tdata, m_axis_tlast);
            m_axis_tready <= quiet || ($urandom_range(99) >= dst_idle_pct);
        end
    end

    task automatic send_pixel(input logic [7:0] pix);
        while (!quiet && $urandom_range(99) < src_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= pix;
        do
            @(posedge clk);
        while (!s_axis_tready);
        grads.note_pixel(pix);
    endtask

    // Stops the stream and waits until every queued result has arrived and
    // any pixel still in the pipeline has been absorbed.
    task automatic drain_block();
        s_axis_tvalid <= 1'b0;
        while (grads.expected_grads.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [svg_pkg::CFG_IDX_W-1:0] idx,
                             input logic [svg_pkg::DIM_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        grads.write_reg(idx, val);
        reg_writes++;
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // A width that grows after row 0 would let the window read line store
    // columns that were never filled in this frame, so growth is kept to
    // the first row.
    task automatic resize_image();
        int                        which;
        int                        pick;
        int                        limit;
        logic [svg_pkg::DIM_W-1:0] w;
        logic [svg_pkg::DIM_W-1:0] h;
        drain_block();
        which = $urandom_range(2);
        pick  = $urandom_range(99);
        if (pick < 10)
            w = svg_pkg::DIM_W'($urandom_range(2));
        else if (pick < 80)
            w = svg_pkg::DIM_W'($urandom_range(12, 3));
        else
            w = svg_pkg::DIM_W'($urandom_range(48, 13));
        if (grads.row_cnt != 0)
        begin
            limit = grads.eff_width();
            if (int'(w) > limit)
                w = svg_pkg::DIM_W'($urandom_range(limit));
        end
        h = ($urandom_range(99) < 10) ? svg_pkg::DIM_W'($urandom_range(2))
                                      : svg_pkg::DIM_W'($urandom_range(9, 3));
        if (which != 1)
            write_reg(svg_pkg::REG_IMAGE_WIDTH, w);
        if (which != 0)
            write_reg(svg_pkg::REG_IMAGE_HEIGHT, h);
    endtask

    function automatic logic [7:0] make_pixel(int style, logic [7:0] base);
        case (style)
            0:       return ($urandom_range(1) != 0) ? 8'hFF : 8'h00;
            1:       return 8'(int'(base) + int'($urandom_range(6)) - 3);
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    task automatic run_random(input int n_items);
        int          sent;
        int          burst;
        int          style;
        logic [7:0]  base;
        sent = 0;
        while (sent < n_items)
        begin
            if ($urandom_range(99) < 10)
                resize_image();
            else if ($urandom_range(99) < 3)
                drain_block();
            quiet = ($urandom_range(99) < 15);
            burst = $urandom_range(60, 1);
            style = $urandom_range(5);
            base  = 8'($urandom_range(255));
            repeat (burst)
                send_pixel(make_pixel(style, base));
            sent += burst;
        end
        quiet = 1'b0;
    endtask

    task automatic finish_frame();
        while (grads.col_cnt != 0 || grads.row_cnt != 0)
            send_pixel(8'($urandom_range(255)));
    endtask

    task automatic run_directed();
        logic [7:0] second_row [5];
        second_row = '{8'h55, 8'hAA, 8'h00, 8'hFF, 8'h0F};
        // A few pixels under the reset size, then a shrink that ends row 0
        // at the next pixel.
        repeat (7) send_pixel(8'hFF);
        drain_block();
        write_reg(svg_pkg::REG_IMAGE_WIDTH, 13'd5);
        write_reg(svg_pkg::REG_IMAGE_HEIGHT, 13'd4);
        send_pixel(8'hFF);
        foreach (second_row[k])
            send_pixel(second_row[k]);
        repeat (5) send_pixel(8'h00);
        repeat (5) send_pixel(8'hFF);
    endtask

    initial
    begin
        grads         = new();
        rst_n         <= 1'b0;
        cfg_we        <= 1'b0;
        cfg_index     <= svg_pkg::REG_IMAGE_WIDTH;
        cfg_data      <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        m_axis_tready <= 1'b0;
        cycle_count   <= 0;
        quiet         = 1'b0;
        reg_writes    = 0;
        src_idle_pct  = 25;
        dst_idle_pct  = 74;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();
        run_random(RANDOM_ITEMS);

        src_idle_pct = 74;
        dst_idle_pct = 25;
        run_random(RANDOM_ITEMS);

        src_idle_pct = 0;
        dst_idle_pct = 0;
        run_random(RANDOM_ITEMS);

        // A saturating width lets row 0 run well past the reset width until
        // a shrink ends it.
        finish_frame();
        drain_block();
        write_reg(svg_pkg::REG_IMAGE_WIDTH, 13'd8191);
        write_reg(svg_pkg::REG_IMAGE_HEIGHT, 13'd3);
        repeat (WIDE_PIXELS) send_pixel(8'($urandom_range(255)));
        drain_block();
        write_reg(svg_pkg::REG_IMAGE_WIDTH, 13'd4);
        finish_frame();

        // A saturating height keeps the frame open over TALL_ROWS rows until a
        // shrink ends the frame.
        drain_block();
        write_reg(svg_pkg::REG_IMAGE_HEIGHT, 13'd8191);
        repeat (TALL_ROWS * 4) send_pixel(8'($urandom_range(255)));
        drain_block();
        write_reg(svg_pkg::REG_IMAGE_HEIGHT, 13'd3);
        finish_frame();

        drain_block();
        write_reg(svg_pkg::REG_IMAGE_WIDTH, 13'd2);
        write_reg(svg_pkg::REG_IMAGE_HEIGHT, 13'd0);
        repeat (9) send_pixel(8'($urandom_range(255)));

        drain_block();
        grads.errors += grads.expected_grads.size();
        $display("Streamed %0d pixels in %0d complete frames with %0d size register writes.",
                 grads.pixels_seen, grads.frames_done, reg_writes);
        $display("Checked %0d gradients, %0d clamped at 255 and %0d clamped at 0; %0d errors.",
                 grads.grads_checked, grads.clamped_high, grads.clamped_low, grads.errors);
        if (grads.errors == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/svg_pkg.sv
hdl/svg_ram.sv
hdl/svg_front.sv
hdl/svg_back.sv
hdl/sobel_vertical_gradient_clamp.sv
sim/tb_sobel_vertical_gradient_clamp.sv
